### rtl/core/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

    localparam int SQUARE_SIDE = 5;

    // letter coding: 0 = a .. 25 = z
    localparam int LETTER_W = 5;
    localparam int LETTERS  = 26;
    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam int OPCODE_W = 3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_KEY     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ENCRYPT = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DECRYPT = 3'd4;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INCOMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAME       = 2'd2;

    // pair letters: saturate out-of-range codes to z, then fold j onto i
    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] x);
        logic [LETTER_W-1:0] y;
        y = (x > LETTER_Z) ? LETTER_Z : x;
        if (y == LETTER_J)
        begin
            y = LETTER_I;
        end
        return y;
    endfunction

endpackage

`default_nettype wire

### rtl/core/digraph_square_cipher.sv
`default_nettype none

// Channel   Handshake              Fields
// command   cmd_valid / cmd_stall  opcode, first_letter, second_letter, last_pair
// response  rsp_valid / rsp_stall  out_first, out_second, status, last_out
//
// One item at a time; cmd_stall is high while an item is being worked on.
// Clear, key letter and unused opcodes go from idle to done. A cipher pair passes
// S_POS and S_CELL, set by the two dependent reads (position memory, then square
// memory), unless it ends in an incomplete-square or identical-letters status.
// Finish: a to z, one candidate letter per cycle through the single write port.
// The response register lets the next item be taken while a result waits on rsp_stall.
// Reset (rst_n, async) empties the square; memory contents need no clearing pass.
module digraph_square_cipher #(
    parameter int SQUARE_SIDE = dsc_pkg::SQUARE_SIDE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire logic [dsc_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [dsc_pkg::LETTER_W-1:0]  first_letter,
    input  wire logic [dsc_pkg::LETTER_W-1:0]  second_letter,
    input  wire logic                          last_pair,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [dsc_pkg::LETTER_W-1:0]  out_first,
    output logic      [dsc_pkg::LETTER_W-1:0]  out_second,
    output logic      [dsc_pkg::STATUS_W-1:0]  status,
    output logic                               last_out
);

    localparam int CELLS   = SQUARE_SIDE * SQUARE_SIDE;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int FILL_W  = $clog2(CELLS + 1);
    localparam int RC_W    = $clog2(SQUARE_SIDE);
    localparam int LTR_W   = dsc_pkg::LETTER_W;
    localparam int LETTERS = dsc_pkg::LETTERS;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CELLS);
    localparam logic [IDX_W-1:0]  SIDE_IDX  = IDX_W'(SQUARE_SIDE);
    localparam logic [RC_W:0]     SIDE_RC   = (RC_W + 1)'(SQUARE_SIDE);
    localparam logic [RC_W:0]     STEP_FWD  = (RC_W + 1)'(1);
    localparam logic [RC_W:0]     STEP_BACK = (RC_W + 1)'(SQUARE_SIDE - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_CELL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // row of a cell index, by compare against each row start
    function automatic logic [RC_W-1:0] cell_row(input logic [IDX_W-1:0] p);
        logic [RC_W-1:0] r;
        r = '0;
        for (int i = 1; i < SQUARE_SIDE; i++)
        begin
            if (p >= IDX_W'(i * SQUARE_SIDE))
            begin
                r = RC_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [RC_W-1:0] cell_col(input logic [IDX_W-1:0] p,
                                                 input logic [RC_W-1:0]  r);
        logic [IDX_W-1:0] c;
        c = p - IDX_W'(r) * SIDE_IDX;
        return c[RC_W-1:0];
    endfunction

    // shift one place along a row or column, with wrap
    function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] c,
                                                  input logic [RC_W:0]   step);
        logic [RC_W:0] s;
        s = {1'b0, c} + step;
        if (s >= SIDE_RC)
        begin
            s = s - SIDE_RC;
        end
        return s[RC_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] cell_idx(input logic [RC_W-1:0] r,
                                                  input logic [RC_W-1:0] c);
        return IDX_W'(r) * SIDE_IDX + IDX_W'(c);
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LETTERS-1:0] present_reg, present_next;
    logic [LTR_W-1:0]   fin_ltr_reg, fin_ltr_next;
    logic               decrypt_reg, decrypt_next;
    logic               last_reg, last_next;

    logic [LTR_W-1:0]             res_first_reg, res_first_next;
    logic [LTR_W-1:0]             res_second_reg, res_second_next;
    logic [dsc_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [LTR_W-1:0]             rsp_first_reg, rsp_first_next;
    logic [LTR_W-1:0]             rsp_second_reg, rsp_second_next;
    logic [dsc_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic                         rsp_last_reg, rsp_last_next;

    logic             accept;
    logic             rsp_free;
    logic             place_en;
    logic [LTR_W-1:0] place_ltr;
    logic [LTR_W-1:0] key_ltr;
    logic [LTR_W-1:0] pair_a;
    logic [LTR_W-1:0] pair_b;

    logic [IDX_W-1:0] pos_a;
    logic [IDX_W-1:0] pos_b;
    logic [LTR_W-1:0] cell_a;
    logic [LTR_W-1:0] cell_b;

    logic [RC_W-1:0]  row1, col1, row2, col2;
    logic [RC_W-1:0]  row1_n, col1_n, row2_n, col2_n;
    logic [RC_W:0]    step;
    logic [IDX_W-1:0] idx1, idx2;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign accept     = cmd_valid && !cmd_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid  = rsp_valid_reg;
    assign out_first  = rsp_first_reg;
    assign out_second = rsp_second_reg;
    assign status     = rsp_status_reg;
    assign last_out   = rsp_last_reg;

    assign key_ltr = (first_letter == dsc_pkg::LETTER_J) ? dsc_pkg::LETTER_I : first_letter;
    assign pair_a  = dsc_pkg::fold_letter(first_letter);
    assign pair_b  = dsc_pkg::fold_letter(second_letter);

    // Placement: key letter on accept, or the finish sweep letter. Both write
    // the square at the fill index and the position table at the letter.
    always_comb
    begin
        place_ltr = key_ltr;
        place_en  = 1'b0;
        if (state_reg == S_FILL)
        begin
            place_ltr = fin_ltr_reg;
            place_en  = (fin_ltr_reg != dsc_pkg::LETTER_J);
        end
        else if (accept && opcode == dsc_pkg::OP_KEY)
        begin
            place_en = (first_letter < LTR_W'(LETTERS));
        end
        place_en = place_en && (fill_reg != FILL_FULL) && !present_reg[place_ltr];
    end

    // square lookup: rows and columns of the two positions read last cycle
    always_comb
    begin
        row1 = cell_row(pos_a);
        col1 = cell_col(pos_a, row1);
        row2 = cell_row(pos_b);
        col2 = cell_col(pos_b, row2);
        step = decrypt_reg ? STEP_BACK : STEP_FWD;
        row1_n = row1;
        col1_n = col1;
        row2_n = row2;
        col2_n = col2;
        if (row1 == row2)
        begin
            col1_n = wrap_step(col1, step);
            col2_n = wrap_step(col2, step);
        end
        else if (col1 == col2)
        begin
            row1_n = wrap_step(row1, step);
            row2_n = wrap_step(row2, step);
        end
        else
        begin
            col1_n = col2;
            col2_n = col1;
        end
        idx1 = cell_idx(row1_n, col1_n);
        idx2 = cell_idx(row2_n, col2_n);
    end

    // Each item finishes its writes before the next is taken, and a cipher
    // only reads on a full square, so reads never meet a pending write.
    dsc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LETTERS)
    ) u_pos_ram (
        .clk     (clk),
        .we      (place_en),
        .waddr   (place_ltr),
        .wdata   (fill_reg[IDX_W-1:0]),
        .raddr_a (pair_a),
        .raddr_b (pair_b),
        .rdata_a (pos_a),
        .rdata_b (pos_b)
    );

    dsc_ram #(
        .WIDTH (LTR_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk     (clk),
        .we      (place_en),
        .waddr   (fill_reg[IDX_W-1:0]),
        .wdata   (place_ltr),
        .raddr_a (idx1),
        .raddr_b (idx2),
        .rdata_a (cell_a),
        .rdata_b (cell_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        present_next    = present_reg;
        fin_ltr_next    = fin_ltr_reg;
        decrypt_next    = decrypt_reg;
        last_next       = last_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_first_next  = rsp_first_reg;
        rsp_second_next = rsp_second_reg;
        rsp_status_next = rsp_status_reg;
        rsp_last_next   = rsp_last_reg;

        if (place_en)
        begin
            fill_next               = fill_reg + FILL_W'(1);
            present_next[place_ltr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next       = last_pair;
                    decrypt_next    = (opcode == dsc_pkg::OP_DECRYPT);
                    res_first_next  = '0;
                    res_second_next = '0;
                    res_status_next = dsc_pkg::STAT_OK;
                    state_next      = S_DONE;
                    priority if (opcode == dsc_pkg::OP_CLEAR)
                    begin
                        fill_next    = '0;
                        present_next = '0;
                    end
                    else if (opcode == dsc_pkg::OP_FINISH)
                    begin
                        fin_ltr_next = '0;
                        state_next   = S_FILL;
                    end
                    else if (opcode == dsc_pkg::OP_ENCRYPT || opcode == dsc_pkg::OP_DECRYPT)
                    begin
                        priority if (fill_reg != FILL_FULL)
                        begin
                            res_status_next = dsc_pkg::STAT_INCOMPLETE;
                        end
                        else if (pair_a == pair_b)
                        begin
                            res_status_next = dsc_pkg::STAT_SAME;
                        end
                        else
                        begin
                            state_next = S_POS;
                        end
                    end
                    else
                    begin
                        // key letter placed above; unused opcodes do nothing
                        state_next = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                fin_ltr_next = fin_ltr_reg + LTR_W'(1);
                if (fin_ltr_reg == dsc_pkg::LETTER_Z)
                begin
                    state_next = S_DONE;
                end
            end
            S_POS:
            begin
                state_next = S_CELL;
            end
            S_CELL:
            begin
                res_first_next  = cell_a;
                res_second_next = cell_b;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_first_next  = res_first_reg;
                    rsp_second_next = res_second_reg;
                    rsp_status_next = res_status_reg;
                    rsp_last_next   = last_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            present_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            present_reg   <= present_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_ltr_reg    <= fin_ltr_next;
        decrypt_reg    <= decrypt_next;
        last_reg       <= last_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        res_status_reg <= res_status_next;
        rsp_first_reg  <= rsp_first_next;
        rsp_second_reg <= rsp_second_next;
        rsp_status_reg <= rsp_status_next;
        rsp_last_reg   <= rsp_last_next;
    end

endmodule

`default_nettype wire

### rtl/core/dsc_ram.sv
`default_nettype none

// one write port, two read ports, read data registered
module dsc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/dsc_checker.sv
`default_nettype none

module dsc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_stall,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_stall,
    input wire logic [dsc_pkg::LETTER_W-1:0]  out_first,
    input wire logic [dsc_pkg::LETTER_W-1:0]  out_second,
    input wire logic [dsc_pkg::STATUS_W-1:0]  status,
    input wire logic                          last_out
);

    // a held response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_first) && $stable(out_second)
            && $stable(status) && $stable(last_out))
        else $error("response changed while stalled");

    // one item at a time: busy in the cycle after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while previous item in flight");

    // errors carry no letters
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != dsc_pkg::STAT_OK |-> out_first == '0 && out_second == '0)
        else $error("letters on error response");

    // only defined status codes, letters from the square alphabet
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == dsc_pkg::STAT_OK || status == dsc_pkg::STAT_INCOMPLETE
            || status == dsc_pkg::STAT_SAME)
            && out_first <= dsc_pkg::LETTER_Z && out_second <= dsc_pkg::LETTER_Z
            && out_first != dsc_pkg::LETTER_J && out_second != dsc_pkg::LETTER_J)
        else $error("bad response code or letter");

endmodule

bind digraph_square_cipher dsc_checker u_dsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_first  (out_first),
    .out_second (out_second),
    .status     (status),
    .last_out   (last_out)
);

`default_nettype wire

### verif/digraph_square_cipher_tb.sv
`default_nettype none

module digraph_square_cipher_tb;

    localparam int CELLS          = dsc_pkg::SQUARE_SIDE * dsc_pkg::SQUARE_SIDE;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int HOLD_OFF_LEN   = 200;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 40;    // allow margin after the last result
    localparam int WATCHDOG_TIME  = 24_000_000;

    // one result item as the block presents it
    typedef struct packed {
        logic [dsc_pkg::LETTER_W-1:0] letter_a;
        logic [dsc_pkg::LETTER_W-1:0] letter_b;
        logic [dsc_pkg::STATUS_W-1:0] stat;
        logic                         last_flag;
    } digraph_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_stall;
    logic [dsc_pkg::OPCODE_W-1:0]  opcode;
    logic [dsc_pkg::LETTER_W-1:0]  first_letter;
    logic [dsc_pkg::LETTER_W-1:0]  second_letter;
    logic                          last_pair;
    logic                          rsp_valid;
    logic                          rsp_stall;
    logic [dsc_pkg::LETTER_W-1:0]  out_first;
    logic [dsc_pkg::LETTER_W-1:0]  out_second;
    logic [dsc_pkg::STATUS_W-1:0]  status;
    logic                          last_out;

    // predictor's own copy of the key square
    logic [dsc_pkg::LETTER_W-1:0]  sq_letter [CELLS];
    logic [dsc_pkg::LETTER_W-1:0]  letter_cell [dsc_pkg::LETTERS];
    logic [dsc_pkg::LETTERS-1:0]   placed_mask;
    int                            cells_filled;

    digraph_t             expected_digraphs [$];
    int                   error_count;
    int                   items_sent;
    bit                   idle_on;        // random gaps/stalls enabled on both sides
    bit                   hold_off_req;   // asks the receiver for one long hold-off

    digraph_square_cipher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .opcode        (opcode),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .last_pair     (last_pair),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_first     (out_first),
        .out_second    (out_second),
        .status        (status),
        .last_out      (last_out)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // append a letter to the square unless full or already placed
    function automatic void place_key_letter(logic [dsc_pkg::LETTER_W-1:0] x);
        if (x < dsc_pkg::LETTERS && cells_filled < CELLS && !placed_mask[x])
        begin
            sq_letter[cells_filled] = x;
            letter_cell[x]          = dsc_pkg::LETTER_W'(cells_filled);
            placed_mask[x]          = 1'b1;
            cells_filled++;
        end
    endfunction

    // pair letters: codes above z saturate to z, j shares the i cell
    function automatic logic [dsc_pkg::LETTER_W-1:0] sat_fold(
            logic [dsc_pkg::LETTER_W-1:0] x);
        logic [dsc_pkg::LETTER_W-1:0] y;
        y = (x > dsc_pkg::LETTER_Z) ? dsc_pkg::LETTER_Z : x;
        return (y == dsc_pkg::LETTER_J) ? dsc_pkg::LETTER_I : y;
    endfunction

    function automatic digraph_t predict_digraph(logic [dsc_pkg::OPCODE_W-1:0] op,
                                                 logic [dsc_pkg::LETTER_W-1:0] a,
                                                 logic [dsc_pkg::LETTER_W-1:0] b,
                                                 logic lp);
        digraph_t                     res;
        logic [dsc_pkg::LETTER_W-1:0] fa;
        logic [dsc_pkg::LETTER_W-1:0] fb;
        int                           ra;
        int                           ca;
        int                           rb;
        int                           cb;
        int                           swap;
        int                           step;
        res           = '0;
        res.last_flag = lp;
        case (op)
            dsc_pkg::OP_CLEAR:
            begin
                placed_mask  = '0;
                cells_filled = 0;
            end
            dsc_pkg::OP_KEY:
            begin
                // out-of-range key codes are dropped, not saturated
                if (a < dsc_pkg::LETTERS)
                begin
                    place_key_letter((a == dsc_pkg::LETTER_J) ? dsc_pkg::LETTER_I : a);
                end
            end
            dsc_pkg::OP_FINISH:
            begin
                for (int x = 0; x < dsc_pkg::LETTERS; x++)
                begin
                    if (x != dsc_pkg::LETTER_J)
                    begin
                        place_key_letter(dsc_pkg::LETTER_W'(x));
                    end
                end
            end
            dsc_pkg::OP_ENCRYPT, dsc_pkg::OP_DECRYPT:
            begin
                fa = sat_fold(a);
                fb = sat_fold(b);
                if (cells_filled < CELLS)
                begin
                    res.stat = dsc_pkg::STAT_INCOMPLETE;
                end
                else if (fa == fb)
                begin
                    res.stat = dsc_pkg::STAT_SAME;
                end
                else
                begin
                    ra   = letter_cell[fa] / dsc_pkg::SQUARE_SIDE;
                    ca   = letter_cell[fa] % dsc_pkg::SQUARE_SIDE;
                    rb   = letter_cell[fb] / dsc_pkg::SQUARE_SIDE;
                    cb   = letter_cell[fb] % dsc_pkg::SQUARE_SIDE;
                    step = (op == dsc_pkg::OP_ENCRYPT) ? 1 : dsc_pkg::SQUARE_SIDE - 1;
                    if (ra == rb)
                    begin
                        ca = (ca + step) % dsc_pkg::SQUARE_SIDE;
                        cb = (cb + step) % dsc_pkg::SQUARE_SIDE;
                    end
                    else if (ca == cb)
                    begin
                        ra = (ra + step) % dsc_pkg::SQUARE_SIDE;
                        rb = (rb + step) % dsc_pkg::SQUARE_SIDE;
                    end
                    else
                    begin
                        swap = ca;
                        ca   = cb;
                        cb   = swap;
                    end
                    res.letter_a = sq_letter[ra * dsc_pkg::SQUARE_SIDE + ca];
                    res.letter_b = sq_letter[rb * dsc_pkg::SQUARE_SIDE + cb];
                end
            end
            default: ;   // unused opcodes: no operation
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command side: one item per call, sometimes a gap afterwards when idling is on
    // ------------------------------------------------------------------
    task automatic send_item(logic [dsc_pkg::OPCODE_W-1:0] op,
                             logic [dsc_pkg::LETTER_W-1:0] a,
                             logic [dsc_pkg::LETTER_W-1:0] b, logic lp);
        int r;
        int gap;
        cmd_valid     <= 1'b1;
        opcode        <= op;
        first_letter  <= a;
        second_letter <= b;
        last_pair     <= lp;
        do
            @(posedge clk);
        while (cmd_stall);
        expected_digraphs.push_back(predict_digraph(op, a, b, lp));
        items_sent++;
        gap = 0;
        if (idle_on)
        begin
            r = $urandom_range(0, 19);
            if (r >= 19)
                gap = $urandom_range(8, 30);
            else if (r >= 12)
                gap = $urandom_range(1, 3);
        end
        // valid only drops when a real gap follows, never low/high in one step
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [dsc_pkg::LETTER_W-1:0] rand_pair_letter();
        // mostly real letters; sometimes the codes above z
        if ($urandom_range(0, 7) == 0)
            return dsc_pkg::LETTER_W'($urandom_range(0, 31));
        return dsc_pkg::LETTER_W'($urandom_range(0, dsc_pkg::LETTERS - 1));
    endfunction

    function automatic logic [dsc_pkg::LETTER_W-1:0] rand_code();
        return dsc_pkg::LETTER_W'($urandom_range(0, 31));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // cipher pair with random direction; now and then identical letters
    task automatic send_random_pair();
        logic [dsc_pkg::OPCODE_W-1:0] op;
        logic [dsc_pkg::LETTER_W-1:0] a;
        logic [dsc_pkg::LETTER_W-1:0] b;
        op = rand_bit() ? dsc_pkg::OP_ENCRYPT : dsc_pkg::OP_DECRYPT;
        a  = rand_pair_letter();
        case ($urandom_range(0, 15))
            0:       b = a;
            1:       b = (a == dsc_pkg::LETTER_I) ? dsc_pkg::LETTER_J : dsc_pkg::LETTER_I;
            default: b = rand_pair_letter();
        endcase
        send_item(op, a, b, rand_bit());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // cipher with no square yet, and the unused opcodes
    task automatic test_empty_square();
        send_item(dsc_pkg::OP_ENCRYPT, 5'd0, 5'd1, 1'b0);
        send_item(dsc_pkg::OP_DECRYPT, 5'd31, 5'd2, 1'b1);
        for (int op = dsc_pkg::OP_DECRYPT + 1; op < (1 << dsc_pkg::OPCODE_W); op++)
        begin
            send_item(dsc_pkg::OPCODE_W'(op), rand_code(), rand_code(), rand_bit());
        end
    endtask

    // key letters: j folded, out-of-range dropped, repeat skipped, extremes
    task automatic test_square_build();
        send_item(dsc_pkg::OP_KEY, dsc_pkg::LETTER_J, 5'd31, 1'b0);
        send_item(dsc_pkg::OP_KEY, 5'd31, 5'd0, 1'b1);
        send_item(dsc_pkg::OP_KEY, 5'd0, 5'd0, 1'b0);
        send_item(dsc_pkg::OP_KEY, 5'd26, 5'd31, 1'b0);
        send_item(dsc_pkg::OP_KEY, 5'd0, 5'd0, 1'b0);
        send_item(dsc_pkg::OP_KEY, dsc_pkg::LETTER_Z, 5'd0, 1'b0);
        send_item(dsc_pkg::OP_FINISH, 5'd0, 5'd0, 1'b0);
        send_item(dsc_pkg::OP_FINISH, 5'd31, 5'd31, 1'b1);   // already full: no effect
        send_item(dsc_pkg::OP_KEY, 5'd3, 5'd0, 1'b0);        // full square: ignored
    endtask

    // square is now  i a z b c / d e f g h / k l m n o / p q r s t / u v w x y
    task automatic test_pair_rules();
        send_item(dsc_pkg::OP_ENCRYPT, 5'd0, 5'd2, 1'b0);     // same row, wraps right
        send_item(dsc_pkg::OP_DECRYPT, 5'd8, 5'd25, 1'b0);    // same row, wraps left
        send_item(dsc_pkg::OP_ENCRYPT, 5'd0, 5'd21, 1'b0);    // same column, wraps down
        send_item(dsc_pkg::OP_DECRYPT, 5'd0, 5'd21, 1'b0);    // same column, wraps up
        send_item(dsc_pkg::OP_ENCRYPT, 5'd4, 5'd18, 1'b0);    // rectangle
        send_item(dsc_pkg::OP_DECRYPT, 5'd18, 5'd4, 1'b0);
        send_item(dsc_pkg::OP_ENCRYPT, 5'd31, 5'd0, 1'b1);    // saturates to z
        // identical once folded
        send_item(dsc_pkg::OP_ENCRYPT, dsc_pkg::LETTER_J, dsc_pkg::LETTER_I, 1'b0);
        send_item(dsc_pkg::OP_DECRYPT, 5'd26, 5'd31, 1'b1);   // both saturate: identical
        send_item(dsc_pkg::OP_CLEAR, 5'd31, 5'd31, 1'b0);
        send_item(dsc_pkg::OP_ENCRYPT, 5'd0, 5'd1, 1'b1);     // cleared: incomplete
    endtask

    // one key session: clear, key letters, usually a finish, then pairs.
    // A little noise is mixed in: stray opcodes, early ciphers, late keys.
    task automatic run_session(int n_pairs);
        int n_keys;
        send_item(dsc_pkg::OP_CLEAR, rand_code(), rand_code(), rand_bit());
        n_keys = $urandom_range(0, 14);
        repeat (n_keys)
        begin
            send_item(dsc_pkg::OP_KEY, rand_pair_letter(), rand_code(), rand_bit());
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_random_pair();
        end
        if ($urandom_range(0, 11) != 0)
        begin
            send_item(dsc_pkg::OP_FINISH, rand_code(), rand_code(), rand_bit());
        end
        repeat (n_pairs)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(dsc_pkg::OPCODE_W'($urandom_range(dsc_pkg::OP_KEY,
                                                            (1 << dsc_pkg::OPCODE_W) - 1)),
                          rand_code(), rand_code(), rand_bit());
            else
                send_random_pair();
        end
    endtask

    task automatic test_random_sessions();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            run_session($urandom_range(8, 40));
        end
    endtask

    // receiver holds off; sender keeps offering until the block backs up
    task automatic test_receiver_hold_off();
        bit saved_idle;
        saved_idle = idle_on;
        idle_on    = 1'b0;
        run_session(2);
        hold_off_req = 1'b1;
        repeat (30) send_random_pair();
        idle_on = saved_idle;
    endtask

    // stretch with no idling on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_session(40);
        run_session(40);
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        opcode        = dsc_pkg::OP_CLEAR;
        first_letter  = '0;
        second_letter = '0;
        last_pair     = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        idle_on       = 1'b1;
        hold_off_req  = 1'b0;
        placed_mask   = '0;
        cells_filled  = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            sq_letter[i] = '0;
        end
        for (int i = 0; i < dsc_pkg::LETTERS; i++)
        begin
            letter_cell[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_square();
        test_square_build();
        test_pair_rules();
        test_receiver_hold_off();
        test_random_sessions();
        test_back_to_back();
        test_receiver_hold_off();

        cmd_valid <= 1'b0;
        while (expected_digraphs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random stall pattern plus the occasional hold-off
    // ------------------------------------------------------------------
    initial
    begin : response_stall
        int hold;
        rsp_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_stall   <= 1'b1;
                hold         = HOLD_OFF_LEN;
            end
            else if (!idle_on || $urandom_range(0, 2) != 0)
            begin
                rsp_stall <= 1'b0;
                hold       = $urandom_range(1, 8);
            end
            else
            begin
                rsp_stall <= 1'b1;
                hold       = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            repeat (hold) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest outstanding expectation
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        digraph_t exp_item;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_digraphs.size() == 0)
            begin
                $error("result item with nothing outstanding");
                error_count++;
            end
            else
            begin
                exp_item = expected_digraphs.pop_front();
                compare_field("out_first",  32'(exp_item.letter_a),  32'(out_first));
                compare_field("out_second", 32'(exp_item.letter_b),  32'(out_second));
                compare_field("status",     32'(exp_item.stat),      32'(status));
                compare_field("last_out",   32'(exp_item.last_flag), 32'(last_out));
            end
        end
    end

    // hard limit on run time
    initial
    begin
        #(WATCHDOG_TIME);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/dsc_pkg.sv
rtl/core/dsc_ram.sv
rtl/core/digraph_square_cipher.sv
rtl/core/dsc_checker.sv
verif/digraph_square_cipher_tb.sv
